// File: sv/gauss_seidel_linear_solver_assert.svh
// assertion macros shared by the solver checker
`ifndef GAUSS_SEIDEL_LINEAR_SOLVER_ASSERT_SVH
`define GAUSS_SEIDEL_LINEAR_SOLVER_ASSERT_SVH

// same-cycle implication on the solver clock
`define GSLS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication on the solver clock
`define GSLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/gsls_pkg.sv
// shared types, constants and arithmetic helpers of the gauss-seidel solver
package gsls_pkg;

   localparam int MAX_EQUATIONS = 16;
   localparam int FRACTION_BITS = 16;
   localparam int ROW_WORDS     = MAX_EQUATIONS + 1;
   localparam int STORE_DEPTH   = MAX_EQUATIONS * ROW_WORDS;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int IDX_W         = $clog2(MAX_EQUATIONS);
   localparam int CNT_W         = $clog2(ROW_WORDS + 1);
   localparam int ACC_W         = 64;
   localparam int DIV_STEPS     = ACC_W;
   localparam int STEP_W        = $clog2(DIV_STEPS);

   // register indexes of the csr port
   localparam logic [1:0] REG_PLATE_SIZE = 2'd0;
   localparam logic [1:0] REG_TOLERANCE  = 2'd1;
   localparam logic [1:0] REG_MAX_SWEEPS = 2'd2;

   typedef struct packed {
      logic signed [31:0] coefficient;
      logic               last_element;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] solution;
      logic [IDX_W-1:0]   equation_index;
      logic               converged;
      logic               last_result;
   } rsp_payload_type;

   typedef enum logic [4:0] {
      S_LOAD,
      S_SW_RD_II,
      S_SW_RD_KI,
      S_SW_CMP,
      S_SX_RD_I,
      S_SX_RD_K,
      S_SX_WR_I,
      S_SX_WR_K,
      S_INIT,
      S_RD_B,
      S_B,
      S_RD_A,
      S_MUL,
      S_ACC,
      S_DIV_GO,
      S_DIV_WAIT,
      S_CHECK,
      S_OUT
   } state_type;

   // equation count from plate size, clamped to the supported sizes
   function automatic logic [CNT_W-1:0] eq_count(logic [2:0] plate);
      logic [CNT_W-1:0] n;
      case (plate)
         3'd0, 3'd1, 3'd2: n = CNT_W'(1);
         3'd3:             n = CNT_W'(4);
         3'd4:             n = CNT_W'(9);
         default:          n = CNT_W'(16);
      endcase
      return n;
   endfunction

   // word address of row/column in a store of rows w words long
   function automatic logic [ADDR_W-1:0] store_addr(logic [CNT_W-1:0] row,
                                                    logic [CNT_W-1:0] col,
                                                    logic [CNT_W-1:0] w);
      logic [2*CNT_W-1:0] p;
      p = {{CNT_W{1'b0}}, row} * {{CNT_W{1'b0}}, w} + {{CNT_W{1'b0}}, col};
      return p[ADDR_W-1:0];
   endfunction

   // magnitude of a 32-bit signed word
   function automatic logic [32:0] mag32(logic signed [31:0] v);
      logic signed [32:0] e;
      e = {v[31], v};
      return (e < 0) ? 33'(-e) : 33'(e);
   endfunction

   // saturating 64-bit subtraction
   function automatic logic signed [ACC_W-1:0] sub_sat(logic signed [ACC_W-1:0] a,
                                                      logic signed [ACC_W-1:0] b);
      logic signed [ACC_W:0] d;
      d = {a[ACC_W-1], a} - {b[ACC_W-1], b};
      if (d[ACC_W] != d[ACC_W-1]) begin
         return d[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
      end
      return d[ACC_W-1:0];
   endfunction

endpackage

// File: sv/gauss_seidel_linear_solver.sv
// gauss-seidel linear solver top level: matrix store, sequencer and result register
//
// usage:
// - configure plate_size, tolerance and max_sweeps on the csr port while idle
// - send the augmented matrix row-major on req_*, one Q16.16 coefficient per item, N rows
//   of N+1 words, N = (plate_size-1)^2 in 1..16; final item's last_element starts the solve
// - loading takes one item per cycle; elements past N*(N+1) are dropped
// - the solve holds req_stall high; row ordering compares each row pair i < k and
//   swaps the rows word by word when |a_ki| > |a_ii|
// - each unknown update runs through the shared multiply/accumulate path and the
//   64-step bit-serial divider
// - a sweep is N updates plus a check step; the solve ends on tolerance or after
//   max_sweeps sweeps (a max_sweeps of 0 acts as 1)
// - the N solutions then leave on rsp_* one per cycle through an output register;
//   rsp_stall holds the current item and pauses the sequencer
// - loading of the next matrix can start while the final result waits
// - synchronous reset restores the register defaults, clears the solution vector
//   and returns to loading; matrix contents are undefined until written
module gauss_seidel_linear_solver (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  gsls_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output gsls_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_write_data
);
   import gsls_pkg::*;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          n_ff, n_in;
   logic [CNT_W-1:0]          i_ff, i_in;
   logic [CNT_W-1:0]          k_ff, k_in;
   logic [CNT_W-1:0]          j_ff, j_in;
   logic [ADDR_W:0]           pos_ff, pos_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   prod_ff, prod_in;
   logic signed [31:0]        tmp_ff, tmp_in;
   logic signed [31:0]        piv_ff, piv_in;
   logic [15:0]               sweep_ff, sweep_in;
   logic                      unsettled_ff, unsettled_in;
   logic                      conv_ff, conv_in;
   logic [2:0]                plate_ff;
   logic [15:0]               tol_ff;
   logic [15:0]               cap_ff;
   logic signed [31:0]        x_ff [MAX_EQUATIONS];
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_payload_type           rsp_payload_ff, rsp_payload_in;

   logic signed [31:0]        mem [STORE_DEPTH];
   logic signed [31:0]        rd_data_ff;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      wr_en;
   logic [ADDR_W-1:0]         wr_addr;
   logic signed [31:0]        wr_data;

   logic                      x_clr;
   logic                      x_we;
   logic [CNT_W-1:0]          x_idx;
   logic signed [31:0]        x_sel;
   logic [CNT_W-1:0]          w;
   logic [CNT_W-1:0]          n_cur;
   logic [2*CNT_W-1:0]        total;
   logic                      adv;
   logic                      div_start;
   logic                      div_done;
   logic signed [31:0]        div_quot;
   logic signed [32:0]        dx;
   logic [32:0]               dx_mag;
   logic [15:0]               cap_eff;

   gsls_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_ff),
      .divisor  (rd_data_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         plate_ff <= 3'd5;
         tol_ff   <= 16'd66;
         cap_ff   <= 16'd1000;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_PLATE_SIZE: plate_ff <= csr_write_data[2:0];
            REG_TOLERANCE:  tol_ff   <= csr_write_data;
            REG_MAX_SWEEPS: cap_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   // matrix store, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // solution vector
   always_ff @(posedge clock) begin
      if (reset || x_clr) begin
         for (int e = 0; e < MAX_EQUATIONS; e++) begin
            x_ff[e] <= '0;
         end
      end else if (x_we) begin
         x_ff[i_ff[IDX_W-1:0]] <= div_quot;
      end
   end

   // shared read of the solution vector
   always_comb begin
      case (state_ff)
         S_MUL:      x_idx = j_ff;
         S_DIV_WAIT: x_idx = i_ff;
         default:    x_idx = k_ff;
      endcase
      x_sel = x_ff[x_idx[IDX_W-1:0]];
   end

   assign w       = n_ff + 1'b1;
   assign n_cur   = eq_count(plate_ff);
   assign total   = {{CNT_W{1'b0}}, n_cur} * {{CNT_W{1'b0}}, CNT_W'(n_cur + 1'b1)};
   assign cap_eff = (cap_ff == '0) ? 16'd1 : cap_ff;
   assign dx      = {div_quot[31], div_quot} - {x_sel[31], x_sel};
   assign dx_mag  = (dx < 0) ? 33'(-dx) : 33'(dx);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      n_in           = n_ff;
      i_in           = i_ff;
      k_in           = k_ff;
      j_in           = j_ff;
      pos_in         = pos_ff;
      acc_in         = acc_ff;
      prod_in        = prod_ff;
      tmp_in         = tmp_ff;
      piv_in         = piv_ff;
      sweep_in       = sweep_ff;
      unsettled_in   = unsettled_ff;
      conv_in        = conv_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      rd_addr        = store_addr(i_ff, j_ff, w);
      wr_en          = 1'b0;
      wr_addr        = pos_ff[ADDR_W-1:0];
      wr_data        = req_payload.coefficient;
      x_clr          = 1'b0;
      x_we           = 1'b0;
      div_start      = 1'b0;
      adv            = 1'b0;
      req_stall      = (state_ff != S_LOAD);

      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if ({{(2*CNT_W-ADDR_W-1){1'b0}}, pos_ff} < total) begin
                  wr_en  = 1'b1;
                  pos_in = pos_ff + 1'b1;
               end
               if (req_payload.last_element) begin
                  n_in     = n_cur;
                  i_in     = '0;
                  k_in     = CNT_W'(1);
                  pos_in   = '0;
                  state_in = (n_cur == CNT_W'(1)) ? S_INIT : S_SW_RD_II;
               end
            end
         end
         // row ordering for diagonal dominance
         S_SW_RD_II: begin
            rd_addr  = store_addr(i_ff, i_ff, w);
            state_in = S_SW_RD_KI;
         end
         S_SW_RD_KI: begin
            rd_addr  = store_addr(k_ff, i_ff, w);
            piv_in   = rd_data_ff;
            state_in = S_SW_CMP;
         end
         S_SW_CMP: begin
            if (mag32(piv_ff) < mag32(rd_data_ff)) begin
               j_in     = '0;
               state_in = S_SX_RD_I;
            end else begin
               adv = 1'b1;
            end
         end
         S_SX_RD_I: begin
            rd_addr  = store_addr(i_ff, j_ff, w);
            state_in = S_SX_RD_K;
         end
         S_SX_RD_K: begin
            rd_addr  = store_addr(k_ff, j_ff, w);
            tmp_in   = rd_data_ff;
            state_in = S_SX_WR_I;
         end
         S_SX_WR_I: begin
            wr_en    = 1'b1;
            wr_addr  = store_addr(i_ff, j_ff, w);
            wr_data  = rd_data_ff;
            state_in = S_SX_WR_K;
         end
         S_SX_WR_K: begin
            wr_en   = 1'b1;
            wr_addr = store_addr(k_ff, j_ff, w);
            wr_data = tmp_ff;
            j_in    = j_ff + 1'b1;
            if (j_ff == n_ff) adv = 1'b1;
            else              state_in = S_SX_RD_I;
         end
         // sweeps
         S_INIT: begin
            x_clr        = 1'b1;
            sweep_in     = '0;
            unsettled_in = 1'b0;
            i_in         = '0;
            state_in     = S_RD_B;
         end
         S_RD_B: begin
            rd_addr  = store_addr(i_ff, n_ff, w);
            state_in = S_B;
         end
         S_B: begin
            acc_in   = $signed({{(ACC_W-32){rd_data_ff[31]}}, rd_data_ff}) <<< FRACTION_BITS;
            j_in     = '0;
            state_in = S_RD_A;
         end
         S_RD_A: begin
            if (j_ff == n_ff) begin
               rd_addr  = store_addr(i_ff, i_ff, w);
               state_in = S_DIV_GO;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + 1'b1;
            end else begin
               rd_addr  = store_addr(i_ff, j_ff, w);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = rd_data_ff * x_sel;
            state_in = S_ACC;
         end
         S_ACC: begin
            acc_in   = sub_sat(acc_ff, prod_ff);
            j_in     = j_ff + 1'b1;
            state_in = S_RD_A;
         end
         S_DIV_GO: begin
            div_start = 1'b1;
            state_in  = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               x_we = 1'b1;
               if (dx_mag > {17'd0, tol_ff}) unsettled_in = 1'b1;
               if (i_ff + 1'b1 == n_ff) begin
                  sweep_in = sweep_ff + 1'b1;
                  state_in = S_CHECK;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_RD_B;
               end
            end
         end
         S_CHECK: begin
            if (!unsettled_ff) begin
               conv_in  = 1'b1;
               k_in     = '0;
               state_in = S_OUT;
            end else if (sweep_ff >= cap_eff) begin
               conv_in  = 1'b0;
               k_in     = '0;
               state_in = S_OUT;
            end else begin
               unsettled_in = 1'b0;
               i_in         = '0;
               state_in     = S_RD_B;
            end
         end
         // result delivery
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                  = 1'b1;
               rsp_payload_in.solution       = x_sel;
               rsp_payload_in.equation_index = k_ff[IDX_W-1:0];
               rsp_payload_in.converged      = conv_ff;
               rsp_payload_in.last_result    = (k_ff + 1'b1 == n_ff);
               k_in                          = k_ff + 1'b1;
               if (k_ff + 1'b1 == n_ff) state_in = S_LOAD;
            end
         end
         default: state_in = S_LOAD;
      endcase

      // next row pair of the ordering pass
      if (adv) begin
         if (k_ff + 1'b1 < n_ff) begin
            k_in     = k_ff + 1'b1;
            state_in = S_SW_RD_II;
         end else if (i_ff + 2'd2 < n_ff) begin
            i_in     = i_ff + 1'b1;
            k_in     = i_ff + 2'd2;
            state_in = S_SW_RD_II;
         end else begin
            state_in = S_INIT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         n_ff         <= '0;
         i_ff         <= '0;
         k_ff         <= '0;
         j_ff         <= '0;
         pos_ff       <= '0;
         sweep_ff     <= '0;
         unsettled_ff <= 1'b0;
         conv_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         pos_ff       <= pos_in;
         sweep_ff     <= sweep_in;
         unsettled_ff <= unsettled_in;
         conv_ff      <= conv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      acc_ff         <= acc_in;
      prod_ff        <= prod_in;
      tmp_ff         <= tmp_in;
      piv_ff         <= piv_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

// File: sv/gsls_div.sv
// bit-serial signed divider, 64-bit dividend by 32-bit divisor, saturated 32-bit quotient
module gsls_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [gsls_pkg::ACC_W-1:0] dividend,
   input  logic signed [31:0]                divisor,
   output logic                              done,
   output logic signed [31:0]                quotient
);
   import gsls_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0]  num_ff, num_in;
   logic [32:0]       rem_ff, rem_in;
   logic [31:0]       den_ff, den_in;
   logic              neg_ff, neg_in;
   logic              zero_ff, zero_in;
   logic              acc_pos_ff, acc_pos_in;
   logic              acc_neg_ff, acc_neg_in;
   logic [32:0]       shifted;
   logic              fits;

   // one quotient bit per cycle, restoring
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      num_in     = num_ff;
      rem_in     = rem_ff;
      den_in     = den_ff;
      neg_in     = neg_ff;
      zero_in    = zero_ff;
      acc_pos_in = acc_pos_ff;
      acc_neg_in = acc_neg_ff;
      shifted    = {rem_ff[31:0], num_ff[ACC_W-1]};
      fits       = shifted >= {1'b0, den_ff};
      if (start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         num_in     = dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
         den_in     = divisor[31] ? 32'(-divisor) : 32'(divisor);
         rem_in     = '0;
         neg_in     = dividend[ACC_W-1] ^ divisor[31];
         zero_in    = (divisor == '0);
         acc_pos_in = !dividend[ACC_W-1] && (dividend != '0);
         acc_neg_in = dividend[ACC_W-1];
      end else if (busy_ff) begin
         rem_in = fits ? 33'(shifted - {1'b0, den_ff}) : shifted;
         num_in = {num_ff[ACC_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      neg_ff     <= neg_in;
      zero_ff    <= zero_in;
      acc_pos_ff <= acc_pos_in;
      acc_neg_ff <= acc_neg_in;
   end

   // sign, saturation and zero divisor handling
   always_comb begin
      if (zero_ff) begin
         if (acc_pos_ff)      quotient = 32'sh7fffffff;
         else if (acc_neg_ff) quotient = 32'sh80000000;
         else                 quotient = '0;
      end else if (neg_ff) begin
         if ((|num_ff[ACC_W-1:32]) || (num_ff[31] && (|num_ff[30:0])))
            quotient = 32'sh80000000;
         else
            quotient = 32'(-num_ff[31:0]);
      end else begin
         if (|num_ff[ACC_W-1:31]) quotient = 32'sh7fffffff;
         else                     quotient = num_ff[31:0];
      end
   end

   assign done = done_ff;

endmodule

// File: sv/gsls_checker.sv
// port-level checker for the gauss-seidel solver and its bind
`include "gauss_seidel_linear_solver_assert.svh"

module gsls_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input gsls_pkg::req_payload_type req_payload,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input gsls_pkg::rsp_payload_type rsp_payload
);
   import gsls_pkg::*;

   // a stalled result item holds
   `GSLS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "result item changed under stall")

   // the final matrix item starts a solve, which blocks further input
   `GSLS_ASSERT_NEXT(a_solve_busy, req_valid && !req_stall && req_payload.last_element, req_stall, "input taken right after the final matrix item")

   // the top index always closes a run
   `GSLS_ASSERT_NOW(a_last_index, rsp_valid && !rsp_payload.last_result, rsp_payload.equation_index != IDX_W'(MAX_EQUATIONS - 1), "top index without last_result")

endmodule

bind gauss_seidel_linear_solver gsls_checker u_gsls_checker (.*);
